// ===== rtl/iiea_pkg.sv =====
// ----------------------------------------------------------------------------
// iiea_pkg: shared types and codes for the indexed insert/erase array
// Request and response layouts, operation and status codes, and the command
// that the sequencer broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package iiea_pkg;

    // Defaults for the top-level parameters.
    localparam int DEPTH_DEF = 64;
    localparam int WIDTH_DEF = 32;

    // Positions in a cell command cover the full legal range of DEPTH (up to 1024).
    localparam int DEPTH_MAX = 1024;
    localparam int POS_W     = $clog2(DEPTH_MAX + 1);

    // Operation codes carried in the request kind field.
    localparam logic [2:0] K_APPEND = 3'd0;
    localparam logic [2:0] K_POP    = 3'd1;
    localparam logic [2:0] K_INSERT = 3'd2;
    localparam logic [2:0] K_ERASE  = 3'd3;
    localparam logic [2:0] K_READ   = 3'd4;
    localparam logic [2:0] K_CLEAR  = 3'd5;
    localparam logic [2:0] K_RESIZE = 3'd6;
    localparam logic [2:0] K_LAST   = 3'd7;

    // Status codes of a response.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // Cell command codes.
    localparam logic [2:0] OP_NOP  = 3'd0;
    localparam logic [2:0] OP_INS  = 3'd1;
    localparam logic [2:0] OP_DEL  = 3'd2;
    localparam logic [2:0] OP_FILL = 3'd3;
    localparam logic [2:0] OP_READ = 3'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [6:0]  position;
        logic [6:0]  end_position;
        logic [6:0]  count;
        logic [31:0] value;
    } t_req;

    typedef struct packed {
        logic [31:0] read_data;
        logic [6:0]  element_count;
        logic [1:0]  status;
    } t_rsp;

    typedef struct packed {
        logic [2:0]       op;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
    } t_cell_cmd;

endpackage

// ===== rtl/iiea_cell.sv =====
// ----------------------------------------------------------------------------
// iiea_cell: one storage cell of the element chain
// Holds one element and, on command, takes its left neighbor, its right
// neighbor or the request value, or drives its element onto the read bus.
// ----------------------------------------------------------------------------
module iiea_cell import iiea_pkg::*; #(
    parameter int WIDTH = WIDTH_DEF,
    parameter int IDX   = 0
) (
    input  logic             i_clk,
    input  t_cell_cmd        i_cmd,
    input  logic [WIDTH-1:0] i_val,
    input  logic [WIDTH-1:0] i_left,
    input  logic [WIDTH-1:0] i_right,
    output logic [WIDTH-1:0] o_data,
    output logic [WIDTH-1:0] o_rd
);

    localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

    logic [WIDTH-1:0] r_data;
    logic [WIDTH-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_cmd.op)
            OP_INS: begin
                // Cells above the insert point move up by one; the insert point takes the value.
                if (MY_POS > i_cmd.pos) begin
                    n_data = i_left;
                end else if (MY_POS == i_cmd.pos) begin
                    n_data = i_val;
                end
            end
            OP_DEL: begin
                if (MY_POS >= i_cmd.pos) begin
                    n_data = i_right;
                end
            end
            OP_FILL: begin
                if (MY_POS >= i_cmd.lo && MY_POS < i_cmd.hi) begin
                    n_data = i_val;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_rd   = (i_cmd.op == OP_READ && MY_POS == i_cmd.pos) ? r_data : '0;

endmodule

// ===== rtl/iiea_seq.sv =====
// ----------------------------------------------------------------------------
// iiea_seq: request sequencer for the indexed insert/erase array
// Checks each request against the live count, steps the cell chain through
// insert and erase shifts, and holds the response register.
// ----------------------------------------------------------------------------
module iiea_seq import iiea_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF,
    parameter int WIDTH = WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_stall,
    input  t_req             i_req,
    input  logic [WIDTH-1:0] i_rd_bus,
    output t_cell_cmd        o_cmd,
    output logic [WIDTH-1:0] o_val,
    output logic             o_rsp_valid,
    input  logic             i_rsp_stall,
    output t_rsp             o_rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = POS_W + 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]       r_state, n_state;
    t_req             r_req;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_steps, n_steps;
    logic [1:0]       r_status, n_status;
    logic [WIDTH-1:0] r_rd, n_rd;
    logic             r_out_valid;
    t_rsp             r_out;
    logic             w_out_free;

    logic [EW-1:0] w_n, w_pos, w_end, w_num, w_depth;

    assign w_n     = EW'(r_count);
    assign w_pos   = EW'(r_req.position);
    assign w_end   = EW'(r_req.end_position);
    assign w_num   = EW'(r_req.count);
    assign w_depth = EW'(DEPTH);

    assign w_out_free  = !r_out_valid || !i_rsp_stall;
    assign o_req_stall = (r_state != S_IDLE);
    assign o_val       = WIDTH'(r_req.value);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_steps  = r_steps;
        n_status = r_status;
        n_rd     = r_rd;
        o_cmd    = '{op: OP_NOP, pos: '0, lo: '0, hi: '0};
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_status = ST_OK;
                n_rd     = '0;
                n_steps  = '0;
                case (r_req.kind)
                    K_APPEND: begin
                        if (w_n >= w_depth) begin
                            n_status = ST_FULL;
                        end else begin
                            o_cmd   = '{op: OP_FILL, pos: '0, lo: POS_W'(w_n),
                                        hi: POS_W'(w_n + EW'(1))};
                            n_count = CW'(w_n + EW'(1));
                        end
                    end
                    K_POP: begin
                        if (w_n == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_count = CW'(w_n - EW'(1));
                        end
                    end
                    K_INSERT: begin
                        if (w_pos > w_n) begin
                            n_status = ST_RANGE;
                        end else if (w_n + w_num > w_depth) begin
                            n_status = ST_FULL;
                        end else begin
                            n_steps = CW'(w_num);
                            n_count = CW'(w_n + w_num);
                        end
                    end
                    K_ERASE: begin
                        if (w_pos > w_end || w_end > w_n) begin
                            n_status = ST_RANGE;
                        end else begin
                            n_steps = CW'(w_end - w_pos);
                            n_count = CW'(w_n - (w_end - w_pos));
                        end
                    end
                    K_READ: begin
                        if (w_pos >= w_n) begin
                            n_status = ST_RANGE;
                        end else begin
                            o_cmd = '{op: OP_READ, pos: POS_W'(w_pos), lo: '0, hi: '0};
                            n_rd  = i_rd_bus;
                        end
                    end
                    K_CLEAR: begin
                        n_count = '0;
                    end
                    K_RESIZE: begin
                        if (w_num > w_depth) begin
                            n_status = ST_FULL;
                        end else begin
                            // Only cells from the old end up to the new size take the fill value.
                            o_cmd   = '{op: OP_FILL, pos: '0, lo: POS_W'(w_n),
                                        hi: POS_W'(w_num)};
                            n_count = CW'(w_num);
                        end
                    end
                    K_LAST: begin
                        if (w_n == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            o_cmd = '{op: OP_READ, pos: POS_W'(w_n - EW'(1)), lo: '0, hi: '0};
                            n_rd  = i_rd_bus;
                        end
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
                if (n_steps != '0) begin
                    n_state = S_SHIFT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                // One single-place shift of the chain per cycle.
                o_cmd   = '{op: (r_req.kind == K_INSERT) ? OP_INS : OP_DEL,
                            pos: POS_W'(r_req.position), lo: '0, hi: '0};
                n_steps = r_steps - CW'(1);
                if (r_steps == CW'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_steps     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_steps <= n_steps;
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req_valid) begin
            r_req <= i_req;
        end
        r_status <= n_status;
        r_rd     <= n_rd;
        if (r_state == S_DONE && w_out_free) begin
            r_out.read_data     <= 32'(r_rd);
            r_out.element_count <= 7'(r_count);
            r_out.status        <= r_status;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("live count above capacity");

    a_shift_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SHIFT |-> r_steps != '0)
        else $error("shift state entered with no steps left");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && !o_req_stall) |=> r_state == S_EXEC)
        else $error("accepted request did not start execution");

    a_done_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished request did not reach the response register");
`endif

endmodule

// ===== rtl/indexed_insert_erase_array.sv =====
// ----------------------------------------------------------------------------
// indexed_insert_erase_array: bounded ordered array with insert and erase
// A chain of DEPTH storage cells holds the elements in order; a sequencer
// checks each request against the live count and steps the chain.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                  Payload
//   request   in         i_req_valid / o_req_stall  i_req (t_req)
//   response  out        o_rsp_valid / i_rsp_stall  o_rsp (t_rsp)
//
// A request is taken only while the sequencer is idle. The sequencer checks it in
// S_EXEC, then shifts the chain in S_SHIFT once per shift place (count for an insert,
// range length for an erase), since the chain moves every element by one place per
// cycle, and loads the response register in S_DONE. A new request is not taken
// before the previous one is through. o_req_stall stays high until the response
// register, which may still hold an earlier response under i_rsp_stall, takes the new
// one. Reset (synchronous, active low) clears the live count and control state only.
//
module indexed_insert_erase_array import iiea_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF,
    parameter int WIDTH = WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_stall,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_stall,
    output t_rsp o_rsp
);

    // Command broadcast to all cells, and the request value kept to WIDTH bits.
    t_cell_cmd        w_cmd;
    logic [WIDTH-1:0] w_val;

    // Each cell's stored element, and its contribution to the read bus.
    logic [WIDTH-1:0] w_data [DEPTH];
    logic [WIDTH-1:0] w_rd   [DEPTH];
    logic [WIDTH-1:0] w_rd_bus;

    // The sequencer owns the live count, the shift counter and the response register.
    iiea_seq #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .i_rd_bus    (w_rd_bus),
        .o_cmd       (w_cmd),
        .o_val       (w_val),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    // The cell chain. Cell i sees cell i-1 on its left and cell i+1 on its right.
    // The first cell's left input and the last cell's right input never reach
    // a live element, so they are tied to the request value and to zero.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WIDTH-1:0] w_left;
        logic [WIDTH-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = w_val;
        end else begin : g_inner_left
            assign w_left = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner_right
            assign w_right = w_data[g+1];
        end

        iiea_cell #(
            .WIDTH (WIDTH),
            .IDX   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_val   (w_val),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[g]),
            .o_rd    (w_rd[g])
        );
    end

    // At most one cell matches a read command; the rest drive zero, so the
    // read bus is a plain OR over the chain. The sequencer registers it.
    always_comb begin
        w_rd_bus = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_rd_bus = w_rd_bus | w_rd[i];
        end
    end

endmodule
